// ===== hw/rtl/assert_macros.svh =====
// assertion macros, included by hermite_interpolation_reparam_top
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property holds at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// when the trigger holds, the consequence holds at the same edge
`define ASSERT_IMPLIES(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/hir_pkg.sv =====
// types and constants of the hermite interpolation pipeline
package hir_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned WF        = 30;
  localparam int unsigned VAL_W     = 32;
  localparam int unsigned TIME_W    = 31;
  localparam int unsigned CARRY_W   = 20;
  localparam int unsigned X_W       = 30;

  localparam logic [CARRY_W-1:0] CARRY_RESET = 20'h10000;

  // 1.0 in the q30 curve parameter format
  localparam logic [WF:0] ONE_W = {1'b1, {WF{1'b0}}};

  // angle wrap: integer degrees divided by 360 through a reciprocal
  localparam int unsigned ANG_S_W     = VAL_W + 1;
  localparam int unsigned ANG_N_W     = ANG_S_W - FRAC_BITS;
  localparam logic [ANG_S_W-1:0] HALF_TURN = ANG_S_W'(180) << FRAC_BITS;
  localparam int unsigned RECIP_SHIFT = 25;
  localparam int unsigned RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP_360 = 17'd93207;
  localparam int unsigned TURN_Q_W    = ANG_N_W + RECIP_W - RECIP_SHIFT;
  localparam logic [8:0] DEG_FULL     = 9'd360;

  typedef struct packed {
    logic signed [VAL_W-1:0] p0;
    logic signed [VAL_W-1:0] v0;
    logic signed [VAL_W-1:0] p1;
    logic signed [VAL_W-1:0] v1;
  } hir_vals_t;

  typedef struct packed {
    hir_vals_t         vals;
    logic              remap;
    logic              mirror;
    logic [X_W-1:0]    x;
    logic [TIME_W-1:0] t;
    logic [TIME_W-1:0] span;
  } hir_remap_sb_t;

  typedef struct packed {
    hir_vals_t         vals;
    logic [TIME_W-1:0] t;
  } hir_cubic_sb_t;

endpackage

// ===== hw/rtl/hermite_interpolation_reparam_top.sv =====
// hermite_interpolation_reparam_top: one component of a cubic hermite curve per beat
// the input channel (in_valid_i/in_ready_o) carries start and end value, start and end
// rate, the angle flag, the span and the time point; the output channel
// (out_valid_o/out_ready_i) returns the saturated value and its flag, one result beat
// per input beat, in order.
// the user writes the span cap via cfg_we_i/cfg_wdata_i while no beat is in flight;
// the block does not enforce this. the chain has 108 register stages and takes one
// beat per cycle while the output is not stalled: 4 setup stages, a 32-stage square
// root, 2 stages, a 30-stage divider for the time remap, 2 stages, a 31-stage divider
// for the curve parameter, then 6 blend stages and the output register.
// reset clears every valid bit and sets the span cap to 1.0 (65536).
// when the receiver stalls, the whole pipeline holds, in_ready_o drops and the output
// register keeps its beat until it is taken; nothing is lost or repeated.
`include "assert_macros.svh"
module hermite_interpolation_reparam_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [hir_pkg::CARRY_W-1:0]   cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [31:0]            start_value_i,
  input  logic signed [31:0]            start_rate_i,
  input  logic signed [31:0]            end_value_i,
  input  logic signed [31:0]            end_rate_i,
  input  logic                          is_angle_i,
  input  logic [30:0]                   span_time_i,
  input  logic [30:0]                   time_point_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [31:0]            value_o,
  output logic                          saturated_o
);

  import hir_pkg::*;

  function automatic logic [ANG_N_W-1:0] turn_idx(input logic [VAL_W-1:0] p);
    logic [ANG_S_W-1:0] pe;
    logic [ANG_S_W-1:0] s;
    pe = {p[VAL_W-1], p};
    if (p[VAL_W-1]) begin
      s = HALF_TURN - pe;
    end else begin
      s = pe + HALF_TURN;
    end
    return s[ANG_S_W-1:FRAC_BITS];
  endfunction

  function automatic logic [VAL_W-1:0] wrap_apply(input logic [VAL_W-1:0] p,
                                                  input logic neg,
                                                  input logic [TURN_Q_W-1:0] i);
    logic [17:0]      turns;
    logic [VAL_W-1:0] off;
    turns = 18'(i) * 18'(DEG_FULL);
    off   = VAL_W'({turns, {FRAC_BITS{1'b0}}});
    return neg ? (p + off) : (p - off);
  endfunction

  logic en;
  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // span cap register
  logic [CARRY_W-1:0] carry_q;
  logic [CARRY_W-1:0] tc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= CARRY_RESET;
    end else if (cfg_we_i) begin
      carry_q <= cfg_wdata_i;
    end
  end

  assign tc = (carry_q == '0) ? CARRY_W'(1) : carry_q;

  // s1: input register with span and time clamps
  logic [TIME_W-1:0] span_in;
  logic [TIME_W-1:0] t_in;
  logic              s1_valid_q;
  hir_vals_t         s1_vals_q;
  logic              s1_angle_q;
  logic [TIME_W-1:0] s1_span_q;
  logic [TIME_W-1:0] s1_t_q;

  assign span_in = (span_time_i == '0) ? TIME_W'(1) : span_time_i;
  assign t_in    = (time_point_i > span_in) ? span_in : time_point_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_vals_q  <= '{p0: start_value_i, v0: start_rate_i,
                      p1: end_value_i, v1: end_rate_i};
      s1_angle_q <= is_angle_i;
      s1_span_q  <= span_in;
      s1_t_q     <= t_in;
    end
  end

  // s2: angle integer parts, remap decision, half selection
  logic              remap_d;
  logic              mirror_d;
  logic [X_W-1:0]    x_d;
  logic [TIME_W-1:0] dspan_d;
  logic              s2_valid_q;
  hir_vals_t         s2_vals_q;
  logic              s2_angle_q;
  logic [ANG_N_W-1:0] s2_n0_q, s2_n1_q;
  logic              s2_remap_q, s2_mirror_q;
  logic [X_W-1:0]    s2_x_q;
  logic [TIME_W-1:0] s2_d_q, s2_t_q, s2_span_q;

  always_comb begin
    remap_d  = (s1_span_q > TIME_W'(tc));
    dspan_d  = remap_d ? (s1_span_q - TIME_W'(tc)) : '0;
    mirror_d = ({s1_t_q, 1'b0} > {1'b0, s1_span_q});
    x_d      = mirror_d ? X_W'(s1_span_q - s1_t_q) : X_W'(s1_t_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_vals_q   <= s1_vals_q;
      s2_angle_q  <= s1_angle_q;
      s2_n0_q     <= turn_idx(s1_vals_q.p0);
      s2_n1_q     <= turn_idx(s1_vals_q.p1);
      s2_remap_q  <= remap_d;
      s2_mirror_q <= mirror_d;
      s2_x_q      <= x_d;
      s2_d_q      <= dspan_d;
      s2_t_q      <= s1_t_q;
      s2_span_q   <= s1_span_q;
    end
  end

  // s3: turn counts by reciprocal, partial products of the radicand
  logic [ANG_N_W+RECIP_W-1:0] n0m, n1m;
  logic              s3_valid_q;
  hir_vals_t         s3_vals_q;
  logic              s3_angle_q;
  logic [TURN_Q_W-1:0] s3_i0_q, s3_i1_q;
  logic              s3_remap_q, s3_mirror_q;
  logic [X_W-1:0]    s3_x_q;
  logic [TIME_W-1:0] s3_t_q, s3_span_q;
  logic [TIME_W+14:0] s3_dxl_q, s3_dxh_q;
  logic [2*CARRY_W-1:0] s3_tc2_q;

  assign n0m = s2_n0_q * RECIP_360;
  assign n1m = s2_n1_q * RECIP_360;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_vals_q   <= s2_vals_q;
      s3_angle_q  <= s2_angle_q;
      s3_i0_q     <= n0m[ANG_N_W+RECIP_W-1:RECIP_SHIFT];
      s3_i1_q     <= n1m[ANG_N_W+RECIP_W-1:RECIP_SHIFT];
      s3_remap_q  <= s2_remap_q;
      s3_mirror_q <= s2_mirror_q;
      s3_x_q      <= s2_x_q;
      s3_t_q      <= s2_t_q;
      s3_span_q   <= s2_span_q;
      s3_dxl_q    <= s2_d_q * s2_x_q[14:0];
      s3_dxh_q    <= s2_d_q * s2_x_q[X_W-1:15];
      s3_tc2_q    <= tc * tc;
    end
  end

  // s4: apply the angle wrap, assemble the radicand
  hir_vals_t     wrap_vals;
  logic [63:0]   rad_d;
  logic          s4_valid_q;
  logic [63:0]   s4_rad_q;
  hir_remap_sb_t s4_sb_q;

  always_comb begin
    wrap_vals = s3_vals_q;
    if (s3_angle_q) begin
      wrap_vals.p0 = wrap_apply(s3_vals_q.p0, s3_vals_q.p0[VAL_W-1], s3_i0_q);
      wrap_vals.p1 = wrap_apply(s3_vals_q.p1, s3_vals_q.p1[VAL_W-1], s3_i1_q);
    end
    // tc^2 + 8*d*x
    rad_d = 64'(s3_tc2_q) + ((64'(s3_dxh_q) << 15) + 64'(s3_dxl_q) << 3);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else if (en) begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_rad_q <= rad_d;
      s4_sb_q  <= '{vals: wrap_vals, remap: s3_remap_q, mirror: s3_mirror_q,
                    x: s3_x_q, t: s3_t_q, span: s3_span_q};
    end
  end

  // square root of the radicand
  logic          sq_valid;
  logic [31:0]   sq_root;
  hir_remap_sb_t sq_sb;

  hir_sqrt #(
    .RAD_W (64),
    .SB_W  ($bits(hir_remap_sb_t))
  ) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_valid_q),
    .rad_i   (s4_rad_q),
    .sb_i    (s4_sb_q),
    .valid_o (sq_valid),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // r1: denominator and x*tc
  logic          r1_valid_q;
  logic [32:0]   r1_den_q;
  logic [X_W+CARRY_W-1:0] r1_xtc_q;
  hir_remap_sb_t r1_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_valid_q <= 1'b0;
    end else if (en) begin
      r1_valid_q <= sq_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_den_q <= 33'(tc) + 33'(sq_root);
      r1_xtc_q <= sq_sb.x * tc;
      r1_sb_q  <= sq_sb;
    end
  end

  // r2: rounded numerator 2*x*tc + den/2
  logic          r2_valid_q;
  logic [51:0]   r2_num_q;
  logic [32:0]   r2_den_q;
  hir_remap_sb_t r2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_valid_q <= 1'b0;
    end else if (en) begin
      r2_valid_q <= r1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r2_num_q <= (52'(r1_xtc_q) << 1) + 52'(r1_den_q >> 1);
      r2_den_q <= r1_den_q;
      r2_sb_q  <= r1_sb_q;
    end
  end

  // remapped time
  logic          dv1_valid;
  logic [X_W-1:0] dv1_quo;
  hir_remap_sb_t dv1_sb;

  hir_div #(
    .NUM_W (52),
    .DEN_W (33),
    .Q_W   (X_W),
    .SB_W  ($bits(hir_remap_sb_t))
  ) u_div_remap (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r2_valid_q),
    .num_i   (r2_num_q),
    .den_i   (r2_den_q),
    .sb_i    (r2_sb_q),
    .valid_o (dv1_valid),
    .quo_o   (dv1_quo),
    .sb_o    (dv1_sb)
  );

  // t1: clamp, unmirror, pick remapped or plain time
  logic [X_W-1:0]    qc;
  logic [TIME_W-1:0] tn;
  logic [TIME_W-1:0] t1_t_d;
  logic [TIME_W-1:0] t1_span_d;
  logic              t1_valid_q;
  hir_vals_t         t1_vals_q;
  logic [TIME_W-1:0] t1_t_q, t1_span_q;

  always_comb begin
    qc        = (dv1_quo > X_W'(tc)) ? X_W'(tc) : dv1_quo;
    tn        = dv1_sb.mirror ? (TIME_W'(tc) - TIME_W'(qc)) : TIME_W'(qc);
    t1_t_d    = dv1_sb.remap ? tn : dv1_sb.t;
    t1_span_d = dv1_sb.remap ? TIME_W'(tc) : dv1_sb.span;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t1_valid_q <= 1'b0;
    end else if (en) begin
      t1_valid_q <= dv1_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_vals_q <= dv1_sb.vals;
      t1_t_q    <= t1_t_d;
      t1_span_q <= t1_span_d;
    end
  end

  // t2: numerator t*2^30 + span/2
  logic              t2_valid_q;
  logic [60:0]       t2_num_q;
  logic [TIME_W-1:0] t2_den_q;
  hir_cubic_sb_t     t2_sb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      t2_valid_q <= 1'b0;
    end else if (en) begin
      t2_valid_q <= t1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t2_num_q <= (61'(t1_t_q) << WF) + 61'(t1_span_q >> 1);
      t2_den_q <= t1_span_q;
      t2_sb_q  <= '{vals: t1_vals_q, t: t1_t_q};
    end
  end

  // curve parameter u in q30
  logic          dv2_valid;
  logic [WF:0]   dv2_quo;
  hir_cubic_sb_t dv2_sb;

  hir_div #(
    .NUM_W (61),
    .DEN_W (TIME_W),
    .Q_W   (WF + 1),
    .SB_W  ($bits(hir_cubic_sb_t))
  ) u_div_param (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (t2_valid_q),
    .num_i   (t2_num_q),
    .den_i   (t2_den_q),
    .sb_i    (t2_sb_q),
    .valid_o (dv2_valid),
    .quo_o   (dv2_quo),
    .sb_o    (dv2_sb)
  );

  // c1: u and w = 1 - u
  logic              c1_valid_q;
  logic [WF:0]       c1_u_q, c1_w_q;
  logic [TIME_W-1:0] c1_t_q;
  hir_vals_t         c1_vals_q;
  logic [WF:0]       u_d;

  assign u_d = (dv2_quo > ONE_W) ? ONE_W : dv2_quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c1_valid_q <= 1'b0;
    end else if (en) begin
      c1_valid_q <= dv2_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_u_q    <= u_d;
      c1_w_q    <= ONE_W - u_d;
      c1_t_q    <= dv2_sb.t;
      c1_vals_q <= dv2_sb.vals;
    end
  end

  // c2: squares and cross term
  logic [2*WF+1:0]   uu, ww, uw;
  logic              c2_valid_q;
  logic [WF:0]       c2_u_q, c2_u2_q, c2_w2_q, c2_uw_q;
  logic [TIME_W-1:0] c2_t_q;
  hir_vals_t         c2_vals_q;

  assign uu = c1_u_q * c1_u_q;
  assign ww = c1_w_q * c1_w_q;
  assign uw = c1_u_q * c1_w_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c2_valid_q <= 1'b0;
    end else if (en) begin
      c2_valid_q <= c1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_u_q    <= c1_u_q;
      c2_u2_q   <= uu[2*WF:WF];
      c2_w2_q   <= ww[2*WF:WF];
      c2_uw_q   <= uw[2*WF:WF];
      c2_t_q    <= c1_t_q;
      c2_vals_q <= c1_vals_q;
    end
  end

  // c3: blend weights c, b, e
  logic [WF+1:0]     kk;
  logic [2*WF+2:0]   cc;
  logic [2*WF+1:0]   bb, ee;
  logic              c3_valid_q;
  logic [WF:0]       c3_c_q;
  logic [TIME_W-1:0] c3_b_q, c3_e_q;
  hir_vals_t         c3_vals_q;

  assign kk = (32'(3) << WF) - {c2_u_q, 1'b0};
  assign cc = c2_u2_q * kk;
  assign bb = c2_t_q * c2_w2_q;
  assign ee = c2_t_q * c2_uw_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c3_valid_q <= 1'b0;
    end else if (en) begin
      c3_valid_q <= c2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_c_q    <= cc[2*WF:WF];
      c3_b_q    <= bb[2*WF:WF];
      c3_e_q    <= ee[2*WF:WF];
      c3_vals_q <= c2_vals_q;
    end
  end

  // c4: a = 1 - c
  logic              c4_valid_q;
  logic [WF:0]       c4_a_q, c4_c_q;
  logic [TIME_W-1:0] c4_b_q, c4_e_q;
  hir_vals_t         c4_vals_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c4_valid_q <= 1'b0;
    end else if (en) begin
      c4_valid_q <= c3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_a_q    <= ONE_W - c3_c_q;
      c4_c_q    <= c3_c_q;
      c4_b_q    <= c3_b_q;
      c4_e_q    <= c3_e_q;
      c4_vals_q <= c3_vals_q;
    end
  end

  // c5: the four weighted products
  logic signed [63:0] ap0, cp1, bv0, ev1;
  logic               c5_valid_q;
  logic signed [63:0] c5_ap0_q, c5_cp1_q, c5_bv0_q, c5_ev1_q;

  assign ap0 = $signed({1'b0, c4_a_q}) * c4_vals_q.p0;
  assign cp1 = $signed({1'b0, c4_c_q}) * c4_vals_q.p1;
  assign bv0 = $signed({1'b0, c4_b_q}) * c4_vals_q.v0;
  assign ev1 = $signed({1'b0, c4_e_q}) * c4_vals_q.v1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c5_valid_q <= 1'b0;
    end else if (en) begin
      c5_valid_q <= c4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c5_ap0_q <= ap0;
      c5_cp1_q <= cp1;
      c5_bv0_q <= bv0;
      c5_ev1_q <= ev1;
    end
  end

  // c6: position sum and rate difference
  logic               c6_valid_q;
  logic signed [63:0] c6_pos_q, c6_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c6_valid_q <= 1'b0;
    end else if (en) begin
      c6_valid_q <= c5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c6_pos_q  <= c5_ap0_q + c5_cp1_q;
      c6_rate_q <= c5_bv0_q - c5_ev1_q;
    end
  end

  // output register: floor shifts, sum, saturation
  logic signed [49:0] val_full;
  logic               ovf;
  logic [VAL_W-1:0]   val_d;
  logic               out_valid_q;
  logic [VAL_W-1:0]   value_q;
  logic               sat_q;

  always_comb begin
    val_full = 50'(c6_pos_q >>> WF) + 50'(c6_rate_q >>> FRAC_BITS);
    ovf      = !((&val_full[49:VAL_W-1]) || !(|val_full[49:VAL_W-1]));
    if (!ovf) begin
      val_d = val_full[VAL_W-1:0];
    end else if (val_full[49]) begin
      val_d = {1'b1, {(VAL_W-1){1'b0}}};
    end else begin
      val_d = {1'b0, {(VAL_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= c6_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= val_d;
      sat_q   <= ovf;
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = $signed(value_q);
  assign saturated_o = sat_q;

  `ASSERT_IMPLIES(a_sat_at_limit, out_valid_o && saturated_o,
                  value_o == 32'sh7fffffff || value_o == 32'sh80000000,
                  "saturated beat not at a range limit")
  `ASSERT_IMPLIES(a_param_in_range, dv2_valid, dv2_quo <= ONE_W,
                  "curve parameter above one")
  `ASSERT_IMPLIES(a_remap_within_cap, dv1_valid && dv1_sb.remap, t1_t_d <= TIME_W'(tc),
                  "remapped time beyond the span cap")

endmodule

// ===== hw/rtl/hir_sqrt.sv =====
// pipelined integer square root, one result bit per stage
module hir_sqrt #(
  parameter int unsigned RAD_W = 64,
  parameter int unsigned SB_W  = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic [RAD_W-1:0]     rad_i,
  input  logic [SB_W-1:0]      sb_i,
  output logic                 valid_o,
  output logic [RAD_W/2-1:0]   root_o,
  output logic [SB_W-1:0]      sb_o
);

  localparam int unsigned ROOT_W = RAD_W / 2;

  logic                valid_q [ROOT_W];
  logic [ROOT_W:0]     rem_q   [ROOT_W];
  logic [ROOT_W-1:0]   root_q  [ROOT_W];
  logic [RAD_W-1:0]    low_q   [ROOT_W];
  logic [SB_W-1:0]     sb_q    [ROOT_W];

  for (genvar k = 0; k < ROOT_W; k++) begin : g_step
    logic              valid_in;
    logic [ROOT_W:0]   rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  low_in;
    logic [SB_W-1:0]   sb_in;
    logic [ROOT_W+2:0] trial;
    logic [ROOT_W+2:0] cand;
    logic              take;
    logic [ROOT_W:0]   rem_d;
    logic [ROOT_W-1:0] root_d;
    logic [RAD_W-1:0]  low_d;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign root_in  = '0;
      assign low_in   = rad_i;
      assign sb_in    = sb_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign root_in  = root_q[k-1];
      assign low_in   = low_q[k-1];
      assign sb_in    = sb_q[k-1];
    end

    always_comb begin
      trial  = {rem_in, low_in[RAD_W-1 -: 2]};
      cand   = {1'b0, root_in, 2'b01};
      take   = (trial >= cand);
      // the remainder can reach twice the partial root, one bit wider than the root
      rem_d  = take ? (ROOT_W+1)'(trial - cand) : trial[ROOT_W:0];
      root_d = {root_in[ROOT_W-2:0], take};
      low_d  = low_in << 2;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
        low_q[k]  <= low_d;
        sb_q[k]   <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[ROOT_W-1];
  assign root_o  = root_q[ROOT_W-1];
  assign sb_o    = sb_q[ROOT_W-1];

endmodule

// ===== hw/rtl/hir_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module hir_div #(
  parameter int unsigned NUM_W = 52,
  parameter int unsigned DEN_W = 33,
  parameter int unsigned Q_W   = 30,
  parameter int unsigned SB_W  = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [SB_W-1:0]  sb_i,
  output logic             valid_o,
  output logic [Q_W-1:0]   quo_o,
  output logic [SB_W-1:0]  sb_o
);

  // the caller guarantees the quotient fits in Q_W bits
  logic             valid_q [Q_W];
  logic [DEN_W-1:0] rem_q   [Q_W];
  logic [Q_W-1:0]   low_q   [Q_W];
  logic [Q_W-1:0]   quo_q   [Q_W];
  logic [DEN_W-1:0] den_q   [Q_W];
  logic [SB_W-1:0]  sb_q    [Q_W];

  for (genvar k = 0; k < Q_W; k++) begin : g_step
    logic             valid_in;
    logic [DEN_W-1:0] rem_in;
    logic [Q_W-1:0]   low_in;
    logic [Q_W-1:0]   quo_in;
    logic [DEN_W-1:0] den_in;
    logic [SB_W-1:0]  sb_in;
    logic [DEN_W:0]   trial;
    logic [DEN_W:0]   diff;
    logic             take;
    logic [DEN_W-1:0] rem_d;
    logic [Q_W-1:0]   quo_d;
    logic [Q_W-1:0]   low_d;

    if (k == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = DEN_W'(num_i >> Q_W);
      assign low_in   = num_i[Q_W-1:0];
      assign quo_in   = '0;
      assign den_in   = den_i;
      assign sb_in    = sb_i;
    end else begin : g_next
      assign valid_in = valid_q[k-1];
      assign rem_in   = rem_q[k-1];
      assign low_in   = low_q[k-1];
      assign quo_in   = quo_q[k-1];
      assign den_in   = den_q[k-1];
      assign sb_in    = sb_q[k-1];
    end

    always_comb begin
      trial = {rem_in, low_in[Q_W-1]};
      diff  = trial - {1'b0, den_in};
      take  = (trial >= {1'b0, den_in});
      rem_d = take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      quo_d = {quo_in[Q_W-2:0], take};
      low_d = low_in << 1;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else if (en_i) begin
        valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        low_q[k] <= low_d;
        quo_q[k] <= quo_d;
        den_q[k] <= den_in;
        sb_q[k]  <= sb_in;
      end
    end
  end

  assign valid_o = valid_q[Q_W-1];
  assign quo_o   = quo_q[Q_W-1];
  assign sb_o    = sb_q[Q_W-1];

endmodule
